[hdl/bf_pkg.sv]
// ----------------------------------------------------------------------------
// bf_pkg
// Shared constants and codes for the Blowfish block cipher.
// ----------------------------------------------------------------------------
package bf_pkg;

  localparam int ROUNDS      = 16;
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 10;
  localparam int FUNC_W      = 2;

  localparam int P_DEPTH     = ROUNDS + 2;
  localparam int P_AW        = $clog2(P_DEPTH);
  localparam int S_BOXES     = 4;
  localparam int S_BOX_DEPTH = 256;
  localparam int S_AW        = $clog2(S_BOX_DEPTH);

  // tdata: left_in, right_in, table_index, table_value, zero fill to bytes
  localparam int IN_FIELDS_W = 2 * WORD_W + IDX_W + WORD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * WORD_W;

  localparam logic [FUNC_W-1:0] FUNC_ENC    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEC    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_P   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_WR_S   = 2'd3;

endpackage

[hdl/bf_ram.sv]
// ----------------------------------------------------------------------------
// bf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/blowfish_block_cipher.sv]
// ----------------------------------------------------------------------------
// blowfish_block_cipher
// Blowfish 64-bit block cipher with host-loaded P-array and S-boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry func in in_tuser. func 2 writes a P-array word, func 3
//   writes an S-box word (box in table_index[9:8]); neither yields an output
//   beat. P writes with index 18 or above are dropped.
//   func 0 encrypts and func 1 decrypts the block in left_in/right_in; the
//   result leaves as one output beat.
//   A block runs through these steps in order: acceptance, a load step that
//   applies the first P word and issues the first S-box reads, one step per
//   Feistel round, and a final step for the left whitening. The round rate
//   is set by the S-box memories: their registered read closes a loop of
//   exactly one round per cycle, with the P word for the next round
//   prefetched from its own memory.
//   in_tready is high only while no block is in flight. A finished block
//   waits in the output register; if that register is still full when the
//   next block finishes, the block holds in its last cycle until the
//   receiver takes the pending beat.
//   Reset clears the control state only; the tables must be written before
//   use.
// ----------------------------------------------------------------------------
module blowfish_block_cipher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: left_in[31:0], right_in[63:32], table_index[73:64],
  //        table_value[105:74], zero fill
  input  logic [bf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: func[1:0]
  input  logic [bf_pkg::FUNC_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: left_out[31:0], right_out[63:32]
  output logic [bf_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import bf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [P_AW-1:0]   k_r, k_nxt;
  logic              dec_r, dec_nxt;
  logic [WORD_W-1:0] l_r, l_nxt;
  logic [WORD_W-1:0] r_r, r_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_l_r, out_l_nxt;
  logic [WORD_W-1:0] out_r_r, out_r_nxt;

  logic [WORD_W-1:0] in_left, in_right, in_value;
  logic [IDX_W-1:0]  in_index;
  logic              in_fire;
  logic              out_free;

  logic              p_we;
  logic [P_AW-1:0]   p_raddr;
  logic [WORD_W-1:0] p_rdata;
  logic [WORD_W-1:0] s_rdata [S_BOXES];
  logic [S_AW-1:0]   s_raddr [S_BOXES];

  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] x_val;

  function automatic logic [P_AW-1:0] p_index(input logic dec, input logic [P_AW-1:0] j);
    if (dec) begin
      return P_AW'(ROUNDS + 1) - j;
    end
    return j;
  endfunction

  assign in_left  = in_tdata[WORD_W-1:0];
  assign in_right = in_tdata[2*WORD_W-1:WORD_W];
  assign in_index = in_tdata[2*WORD_W+IDX_W-1:2*WORD_W];
  assign in_value = in_tdata[3*WORD_W+IDX_W-1:2*WORD_W+IDX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign p_we = in_fire && (in_tuser == FUNC_WR_P) && (in_index < IDX_W'(P_DEPTH));

  bf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (P_DEPTH)
  ) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (in_index[P_AW-1:0]),
    .wdata (in_value),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  for (genvar b = 0; b < S_BOXES; b++) begin : g_sbox
    logic s_we;
    assign s_we = in_fire && (in_tuser == FUNC_WR_S) &&
                  (in_index[IDX_W-1:S_AW] == (IDX_W - S_AW)'(b));
    // box 0 takes the most significant byte
    assign s_raddr[b] = x_val[WORD_W-1-b*BYTE_W -: BYTE_W];

    bf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (S_BOX_DEPTH)
    ) u_s_ram (
      .clk   (clk),
      .we    (s_we),
      .waddr (in_index[S_AW-1:0]),
      .wdata (in_value),
      .raddr (s_raddr[b]),
      .rdata (s_rdata[b])
    );
  end

  // round function on the S-box words fetched last cycle, then mix in the
  // prefetched P word to form the next round's left half
  always_comb begin
    f_val = ((s_rdata[0] + s_rdata[1]) ^ s_rdata[2]) + s_rdata[3];
    base  = (state_r == ST_LOAD) ? l_r : (r_r ^ f_val);
    x_val = base ^ p_rdata;
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:  p_raddr = p_index(in_tuser == FUNC_DEC, '0);
      ST_LOAD:  p_raddr = p_index(dec_r, P_AW'(1));
      ST_ROUND: p_raddr = p_index(dec_r, k_r + P_AW'(2));
      default:  p_raddr = p_index(dec_r, P_AW'(ROUNDS + 1));
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    dec_nxt       = dec_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == FUNC_ENC || in_tuser == FUNC_DEC)) begin
          l_nxt     = in_left;
          r_nxt     = in_right;
          dec_nxt   = (in_tuser == FUNC_DEC);
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        l_nxt     = x_val;
        k_nxt     = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (k_r == P_AW'(ROUNDS - 1)) begin
          // last round: skip the swap, whiten the right half
          r_nxt     = x_val;
          state_nxt = ST_FINAL;
        end else begin
          l_nxt = x_val;
          r_nxt = l_r;
          k_nxt = k_r + P_AW'(1);
        end
      end
      default: begin
        if (out_free) begin
          out_l_nxt     = l_r ^ p_rdata;
          out_r_nxt     = r_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    dec_r   <= dec_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};

endmodule

[dv/blowfish_block_cipher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blowfish_block_cipher_tb
// Loads every P-array and S-box word, then drives directed and random
// encrypt, decrypt and table-write beats under several idle and stall
// patterns. A scoreboard keeps its own copy of the tables, predicts each
// block result and checks the output stream beat by beat.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] rhalf;
  logic [31:0] lhalf;
} cipher_block_t;

class cipher_scoreboard;
  logic [31:0]   p_words [bf_pkg::P_DEPTH];
  logic [31:0]   s_words [1024];
  cipher_block_t pending_blocks [$];
  int            errors = 0;

  function logic [31:0] feistel_f(logic [31:0] v);
    logic [31:0] y;
    y = (s_words[{2'd0, v[31:24]}] + s_words[{2'd1, v[23:16]}]) ^ s_words[{2'd2, v[15:8]}];
    y = y + s_words[{2'd3, v[7:0]}];
    return y;
  endfunction

  function cipher_block_t cipher_block(bit decrypt, logic [31:0] lh, logic [31:0] rh);
    cipher_block_t res;
    logic [31:0]   l;
    logic [31:0]   r;
    logic [31:0]   t;
    int            i;
    l = lh;
    r = rh;
    for (int k = 0; k < bf_pkg::ROUNDS; k++) begin
      i = decrypt ? bf_pkg::ROUNDS + 1 - k : k;
      l = l ^ p_words[i];
      r = r ^ feistel_f(l);
      t = l;
      l = r;
      r = t;
    end
    // undo the last swap, then whiten
    res.lhalf = r ^ (decrypt ? p_words[0] : p_words[bf_pkg::ROUNDS + 1]);
    res.rhalf = l ^ (decrypt ? p_words[1] : p_words[bf_pkg::ROUNDS]);
    return res;
  endfunction

  function void take_input(logic [1:0] func, logic [31:0] lh, logic [31:0] rh,
                           logic [9:0] idx, logic [31:0] val);
    case (func)
      bf_pkg::FUNC_ENC: pending_blocks.push_back(cipher_block(1'b0, lh, rh));
      bf_pkg::FUNC_DEC: pending_blocks.push_back(cipher_block(1'b1, lh, rh));
      bf_pkg::FUNC_WR_P: begin
        // drop writes past the last P word
        if (idx < bf_pkg::P_DEPTH) p_words[idx] = val;
      end
      default: s_words[idx] = val;
    endcase
  endfunction

  function void check_output(logic [63:0] data);
    cipher_block_t exp_blk;
    cipher_block_t got;
    got = data;
    if (pending_blocks.size() == 0) begin
      $error("unexpected output beat: left_out %h right_out %h", got.lhalf, got.rhalf);
      errors++;
      return;
    end
    exp_blk = pending_blocks.pop_front();
    if (got.lhalf !== exp_blk.lhalf) begin
      $error("left_out: expected %h, actual %h", exp_blk.lhalf, got.lhalf);
      errors++;
    end
    if (got.rhalf !== exp_blk.rhalf) begin
      $error("right_out: expected %h, actual %h", exp_blk.rhalf, got.rhalf);
      errors++;
    end
  endfunction
endclass

module blowfish_block_cipher_tb;
  import bf_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int               send_idle   = 0;
  int               recv_stall  = 0;
  int               quiet_cycles = 0;
  cipher_scoreboard sb = new();

  always #2 clk = ~clk;

  blowfish_block_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] func, input logic [31:0] lh,
                           input logic [31:0] rh, input logic [9:0] idx,
                           input logic [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {6'b0, val, idx, rh, lh};
    do @(posedge clk); while (!in_tready);
    sb.take_input(func, lh, rh, idx, val);
  endtask

  task automatic send_random();
    logic [1:0] func;
    logic [9:0] idx;
    int         pick;
    pick = $urandom_range(99);
    idx  = 10'($urandom_range(1023));
    if (pick < 40) func = FUNC_ENC;
    else if (pick < 70) func = FUNC_DEC;
    else if (pick < 80) begin
      func = FUNC_WR_P;
      // mostly valid P indexes, some that must be dropped
      if ($urandom_range(3) != 0) idx = 10'($urandom_range(P_DEPTH - 1));
    end else func = FUNC_WR_S;
    send_beat(func, rand_word(), rand_word(), idx, rand_word());
  endtask

  task automatic wait_drain();
    while (sb.pending_blocks.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table word before any block reads it
    for (int i = 0; i < P_DEPTH; i++) send_beat(FUNC_WR_P, $urandom(), $urandom(), 10'(i), $urandom());
    for (int i = 0; i < 1024; i++) send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'(i), $urandom());

    send_beat(FUNC_ENC, 32'h0000_0000, 32'h0000_0000, 10'd0,    32'h0000_0000);
    send_beat(FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF);
    send_beat(FUNC_DEC, 32'h0000_0000, 32'h0000_0000, 10'd1023, 32'hFFFF_FFFF);
    send_beat(FUNC_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0,    32'h0000_0000);
    send_beat(FUNC_ENC, 32'hFFFF_FFFF, 32'h0000_0000, 10'd17,   $urandom());
    send_beat(FUNC_DEC, 32'h0000_0000, 32'hFFFF_FFFF, 10'd18,   $urandom());
    send_beat(FUNC_WR_P, 32'hFFFF_FFFF, 32'h0000_0000, 10'd17,   32'hFFFF_FFFF);
    send_beat(FUNC_WR_P, 32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    32'h0000_0000);
    // out-of-range P writes: must leave the array alone
    send_beat(FUNC_WR_P, $urandom(), $urandom(), 10'd18,   32'hFFFF_FFFF);
    send_beat(FUNC_WR_P, $urandom(), $urandom(), 10'd1023, $urandom());
    send_beat(FUNC_ENC, $urandom(), $urandom(), 10'($urandom()), $urandom());
    send_beat(FUNC_DEC, $urandom(), $urandom(), 10'($urandom()), $urandom());
    send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'd0,    32'hFFFF_FFFF);
    send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'd1023, 32'hFFFF_FFFF);
    send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'd256,  32'hFFFF_FFFF);
    send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'd767,  32'h0000_0000);
    send_beat(FUNC_ENC, 32'h0000_0000, 32'h0000_0000, 10'($urandom()), $urandom());
    send_beat(FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'($urandom()), $urandom());
    send_beat(FUNC_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'($urandom()), $urandom());
    send_beat(FUNC_WR_S, $urandom(), $urandom(), 10'd511,  32'h0000_0000);
    send_beat(FUNC_ENC, $urandom(), $urandom(), 10'($urandom()), $urandom());
    in_tvalid <= 1'b0;
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 70; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 70; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      repeat (RANDOM_ITEMS / 4) send_random();
      // hold the sender until the block has emptied
      in_tvalid <= 1'b0;
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_blocks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/bf_pkg.sv
hdl/bf_ram.sv
hdl/blowfish_block_cipher.sv
dv/blowfish_block_cipher_tb.sv
